>>> rtl/ipmf_pkg.sv
// Shared types and constants of the IPv4 mask filter matcher.
// No dependencies; every other file of the block imports this package.
package ipmf_pkg;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_CHAR   = 2'd2;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam int unsigned RADIX      = 10;
  localparam int unsigned NUM_OCTETS = 4;
  localparam int unsigned MIDX_W     = 10;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] entry_mask;
    logic [31:0] entry_compare;
    logic [7:0]  addr_char;
    logic        addr_last;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic              append_dropped;
    logic              reject;
    logic              matched;
    logic [MIDX_W-1:0] match_index;
    logic [31:0]       packed_address;
  } out_item_t;

  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] compare;
  } entry_t;

  typedef struct packed {
    logic       take;
    logic       last;
    logic [7:0] chr;
  } parse_ctl_t;

endpackage

>>> rtl/ipmf_table.sv
// Filter table storage: one synchronous memory of mask and compare pairs.
// One write port and one read port with registered read data. Uses ipmf_pkg.
module ipmf_table #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  ipmf_pkg::entry_t wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output ipmf_pkg::entry_t rd_data_o
);
  import ipmf_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/ipmf_parse.sv
// Serial address parser: folds characters into four decimal octets.
// Presents the packed address as it stands after the current character. Uses ipmf_pkg.
module ipmf_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ipmf_pkg::parse_ctl_t ctl_i,
  output logic [31:0]          addr_o
);
  import ipmf_pkg::*;

  logic [7:0] oct_q [NUM_OCTETS];
  logic [7:0] oct_d [NUM_OCTETS];
  logic [2:0] pos_q, pos_d;
  logic       stop_q, stop_d;
  logic       is_digit;
  logic [7:0] digit;
  logic [7:0] cur;
  logic [2:0] pos_inc;

  assign is_digit = (ctl_i.chr >= CHAR_ZERO) && (ctl_i.chr <= CHAR_NINE);
  assign digit    = ctl_i.chr - CHAR_ZERO;
  assign cur      = oct_q[pos_q[1:0]];
  assign pos_inc  = pos_q + 3'd1;

  always_comb begin
    for (int k = 0; k < NUM_OCTETS; k++) begin
      oct_d[k] = oct_q[k];
    end
    pos_d  = pos_q;
    stop_d = stop_q;
    if (ctl_i.take && !stop_q) begin
      if (ctl_i.chr == CHAR_NUL || ctl_i.chr == CHAR_COLON) begin
        stop_d = 1'b1;
      end else if (is_digit) begin
        oct_d[pos_q[1:0]] = 8'(16'(cur) * 16'(RADIX) + 16'(digit));
      end else begin
        pos_d = pos_inc;
        if (32'(pos_inc) >= NUM_OCTETS) begin
          stop_d = 1'b1;
        end
      end
    end
  end

  assign addr_o = {oct_d[3], oct_d[2], oct_d[1], oct_d[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_OCTETS; k++) begin
        oct_q[k] <= 8'd0;
      end
      pos_q  <= 3'd0;
      stop_q <= 1'b0;
    end else if (ctl_i.take && ctl_i.last) begin
      for (int k = 0; k < NUM_OCTETS; k++) begin
        oct_q[k] <= 8'd0;
      end
      pos_q  <= 3'd0;
      stop_q <= 1'b0;
    end else begin
      oct_q  <= oct_d;
      pos_q  <= pos_d;
      stop_q <= stop_d;
    end
  end

endmodule

>>> rtl/ip_mask_filter_matcher.sv
// Top level of the IPv4 mask filter matcher: request decode, table scan and result register.
// Instantiates ipmf_table and ipmf_parse; uses ipmf_pkg.
//
// Usage: requests arrive on the input channel (in_valid_i / in_stall_o / in_data_i) and a
// transfer happens at a clock edge with valid high and stall low. A clear empties the table
// and gives no result. An append writes one mask and compare pair and returns an
// acknowledgement in the cycle after its transfer, with append_dropped set when the table was
// already full. Address characters are taken one per cycle while the input is not stalled
// and give no result, except the one marked last: it starts a scan of the table from entry 0,
// reading one entry per memory read cycle through the single read port of the table. The
// first match stops the scan, otherwise it runs through every filled entry, and the verdict
// is then registered. The input channel stalls during the scan.
// Results leave through a registered output channel (out_valid_o / out_stall_i / out_data_o).
// While the receiver stalls, the result holds and the input stalls until that result has
// left, whatever the next request is.
// The ban_mode register is written over the cfg channel, which is always ready.
// Reset empties the table, clears the parse state and sets ban_mode to 1.
module ip_mask_filter_matcher #(
  parameter int unsigned MAX_FILTERS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ipmf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ipmf_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import ipmf_pkg::*;

  // Address width of the table and width of the fill count, which must also hold MAX_FILTERS.
  localparam int unsigned AW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FILTERS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic             state_q, state_d;
  logic             ban_mode_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  logic [31:0]      addr_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             in_acc;
  logic             is_append, is_clear, is_char, is_last;
  logic             table_full;
  logic             hit, exhausted;
  logic             rd_en;
  entry_t           rd_data;
  entry_t           wr_data;
  parse_ctl_t       pctl;
  logic [31:0]      parse_addr;

  // The input waits during a scan, and whenever a held result has not yet left.
  assign in_stall_o = (state_q == ST_SCAN) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_clear  = in_acc && (in_data_i.req_type == REQ_CLEAR);
  assign is_append = in_acc && (in_data_i.req_type == REQ_APPEND);
  assign is_char   = in_acc && (in_data_i.req_type == REQ_CHAR);
  assign is_last   = is_char && in_data_i.addr_last;

  assign table_full = (32'(count_q) >= MAX_FILTERS);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ban_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      ban_mode_q <= cfg_data_i;
    end
  end

  assign pctl.take = is_char;
  assign pctl.last = in_data_i.addr_last;
  assign pctl.chr  = in_data_i.addr_char;

  ipmf_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pctl),
    .addr_o (parse_addr)
  );

  assign wr_data.mask    = in_data_i.entry_mask;
  assign wr_data.compare = in_data_i.entry_compare;

  ipmf_table #(
    .DEPTH (MAX_FILTERS),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (is_append && !table_full),
    .wr_addr_i (count_q[AW-1:0]),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (issue_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  // The scan issues one read a cycle and compares the entry read in the previous cycle; a hit
  // ends it at once, and no further read is issued.
  assign hit       = pend_q && ((addr_q & rd_data.mask) == rd_data.compare);
  assign exhausted = (issue_q == count_q);
  assign rd_en     = (state_q == ST_SCAN) && !hit && !exhausted;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (is_clear) begin
          count_d = '0;
        end
        if (is_append) begin
          if (!table_full) begin
            count_d = count_q + 1'b1;
          end
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.result_kind    = KIND_ACK;
          out_d.append_dropped = table_full;
        end
        if (is_last) begin
          state_d = ST_SCAN;
          issue_d = '0;
        end
      end
      ST_SCAN: begin
        if (hit || exhausted) begin
          state_d              = ST_IDLE;
          out_valid_d          = 1'b1;
          out_d.result_kind    = KIND_VERDICT;
          out_d.append_dropped = 1'b0;
          out_d.matched        = hit;
          out_d.reject         = hit ? ban_mode_q : !ban_mode_q;
          out_d.match_index    = hit ? MIDX_W'(pidx_q) : '0;
          out_d.packed_address = addr_q;
        end else begin
          pend_d  = 1'b1;
          pidx_d  = issue_q[AW-1:0];
          issue_d = issue_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    out_q  <= out_d;
    if (is_last) begin
      addr_q <= parse_addr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A scan never reads beyond the filled part of the table.
  a_issue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (issue_q <= count_q))
    else $error("scan read pointer passed the entry count");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_FILTERS)
    else $error("entry count exceeds table capacity");

  a_last_starts_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_last |=> (state_q == ST_SCAN))
    else $error("last character did not start a table scan");

  // A verdict is only ever loaded into an empty or draining output register.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && (hit || exhausted)) |-> !(out_valid_q && out_stall_i))
    else $error("verdict would overwrite a held result");

  a_append_ack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_append |=> (out_valid_q && (out_q.result_kind == KIND_ACK)))
    else $error("append was not acknowledged");

endmodule

>>> dv/ip_mask_filter_matcher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the IPv4 mask filter matcher: a directed table, random filter
// tables and addresses, a full table; each result checked against a written value or the model.
// Depends on ipmf_pkg and the ip_mask_filter_matcher top level from the rtl folder.
module ip_mask_filter_matcher_tb;
  import ipmf_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [7:0]  CHAR_DOT     = ".";
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned QUIET_CYCLES = 16;
  localparam int unsigned TAIL_CYCLES  = TABLE_DEPTH + 64;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam longint unsigned RUN_LIMIT_NS = 64'd40_000_000;

  localparam out_item_t ACK_KEPT    = {KIND_ACK, 1'b0, 44'd0};
  localparam out_item_t ACK_DROPPED = {KIND_ACK, 1'b1, 44'd0};

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t outcome;
  } plan_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b0;

  // Behavioural copy of the block's state.
  logic [31:0] tbl_mask    [TABLE_DEPTH];
  logic [31:0] tbl_compare [TABLE_DEPTH];
  int unsigned live_entries = 0;
  logic [7:0]  octet_acc [NUM_OCTETS];
  int unsigned octet_sel    = 0;
  bit          parse_halted = 1'b0;
  logic        ban_mode_m   = 1'b1;

  out_item_t   outcomes_due[$];
  plan_row_t   directed_plan[$];
  logic [7:0]  addr_text[$];
  int unsigned mismatches      = 0;
  int unsigned items_sent      = 0;
  int unsigned hold_cycles_req = 0;
  bit          src_idle_on     = 1'b1;
  bit          snk_idle_on     = 1'b1;

  ip_mask_filter_matcher #(
    .MAX_FILTERS(TABLE_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Behavioural model
  // ---------------------------------------------------------------------------------------

  function automatic void clear_parse();
    foreach (octet_acc[k]) octet_acc[k] = '0;
    octet_sel    = 0;
    parse_halted = 1'b0;
  endfunction

  // One character of the address string. Digits build the current octet modulo 256, a colon
  // or NUL halts the parse, and anything else moves on, halting when a fifth octet starts.
  function automatic void take_char(input logic [7:0] c);
    int unsigned acc;
    if (parse_halted) return;
    if (c == CHAR_NUL || c == CHAR_COLON) begin
      parse_halted = 1'b1;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      acc = octet_acc[octet_sel] * RADIX + (c - CHAR_ZERO);
      octet_acc[octet_sel] = acc[7:0];
    end else begin
      octet_sel++;
      if (octet_sel >= NUM_OCTETS) parse_halted = 1'b1;
    end
  endfunction

  // Updates the state for one accepted request and returns 1 when it gives a result.
  function automatic bit compute_outcome(input in_item_t it, output out_item_t res);
    logic [31:0] addr;
    int unsigned idx;
    bit          hit;
    res = '0;
    case (it.req_type)
      REQ_CLEAR: begin
        live_entries = 0;
        return 1'b0;
      end
      REQ_APPEND: begin
        res.result_kind = KIND_ACK;
        if (live_entries < TABLE_DEPTH) begin
          tbl_mask[live_entries]    = it.entry_mask;
          tbl_compare[live_entries] = it.entry_compare;
          live_entries++;
        end else begin
          res.append_dropped = 1'b1;
        end
        return 1'b1;
      end
      REQ_CHAR: begin
        take_char(it.addr_char);
        if (!it.addr_last) return 1'b0;
        addr = {octet_acc[3], octet_acc[2], octet_acc[1], octet_acc[0]};
        hit  = 1'b0;
        idx  = 0;
        // The first entry that matches wins, so the scan stops there.
        while (!hit && idx < live_entries) begin
          if ((addr & tbl_mask[idx]) == tbl_compare[idx]) hit = 1'b1;
          else idx++;
        end
        if (!hit) idx = 0;
        res.result_kind    = KIND_VERDICT;
        res.reject         = hit ? ban_mode_m : ~ban_mode_m;
        res.matched        = hit;
        res.match_index    = idx[MIDX_W-1:0];
        res.packed_address = addr;
        clear_parse();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endfunction

  task automatic check_outcome(input out_item_t got);
    out_item_t want;
    if (outcomes_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: result %h arrived with nothing outstanding", $time, got);
    end else begin
      want = outcomes_due.pop_front();
      if (got.result_kind !== want.result_kind)
        flag_mismatch("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      if (got.append_dropped !== want.append_dropped)
        flag_mismatch("append_dropped", 32'(want.append_dropped), 32'(got.append_dropped));
      if (got.reject !== want.reject)
        flag_mismatch("reject", 32'(want.reject), 32'(got.reject));
      if (got.matched !== want.matched)
        flag_mismatch("matched", 32'(want.matched), 32'(got.matched));
      if (got.match_index !== want.match_index)
        flag_mismatch("match_index", 32'(want.match_index), 32'(got.match_index));
      if (got.packed_address !== want.packed_address)
        flag_mismatch("packed_address", want.packed_address, got.packed_address);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap(input bit idle_on);
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.req_type      = 2'($urandom_range(0, 3));
    it.entry_mask    = $urandom;
    it.entry_compare = $urandom;
    it.addr_char     = 8'($urandom);
    it.addr_last     = 1'($urandom);
    return it;
  endfunction

  // Appends with masks of the usual shapes; the compare word mostly lies inside its mask so
  // that the entry can match at all.
  function automatic in_item_t append_item();
    in_item_t    it;
    int unsigned octets;
    it = random_item();
    it.req_type = REQ_APPEND;
    case ($urandom_range(0, 5))
      0: it.entry_mask = '0;
      1: it.entry_mask = '1;
      2: ;
      default: begin
        octets = $urandom_range(1, 3);
        it.entry_mask = (32'd1 << (8 * octets)) - 32'd1;
      end
    endcase
    if ($urandom_range(0, 4) != 0) it.entry_compare = it.entry_compare & it.entry_mask;
    return it;
  endfunction

  // Usually an address that hits a live entry, otherwise an extreme or a random one.
  function automatic logic [31:0] target_address();
    int unsigned j;
    if (live_entries != 0 && $urandom_range(0, 9) < 7) begin
      j = $urandom_range(0, live_entries - 1);
      return tbl_compare[j] | ($urandom & ~tbl_mask[j]);
    end
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_other_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while ((c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_COLON);
    return c;
  endfunction

  task automatic push_number(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int k = 0; k < digits.len(); k++) addr_text.push_back(digits[k]);
  endtask

  // Offers one request and waits for its transfer. Valid stays high afterwards, so that a
  // following request with no gap goes out back to back.
  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t typed_res = '0);
    int unsigned gap;
    out_item_t   res;
    gap = pick_gap(src_idle_on);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (compute_outcome(it, res)) outcomes_due.push_back(typed ? typed_res : res);
    if (it.req_type != REQ_UNUSED) items_sent++;
  endtask

  // Writes a dotted quad for the address, with leading zeros, octets that wrap past 255,
  // odd separators and empty octets mixed in, and sometimes a port, a NUL, a fifth octet, a
  // corrupted byte or a cut. Stray requests are slipped in between the characters now and then.
  task automatic send_address(input logic [31:0] addr);
    int unsigned v;
    int unsigned style;
    int unsigned cut;
    in_item_t    it;
    addr_text.delete();
    for (int k = 0; k < NUM_OCTETS; k++) begin
      if (k != 0) addr_text.push_back($urandom_range(0, 9) == 0 ? pick_other_char() : CHAR_DOT);
      v     = 32'(addr[8*k +: 8]);
      style = $urandom_range(0, 9);
      if (style == 0) v += 256 * $urandom_range(1, 3);
      if (style == 1) addr_text.push_back(CHAR_ZERO);
      if (!(style == 2 && v == 0)) push_number(v);
    end
    case ($urandom_range(0, 9))
      0: begin
        addr_text.push_back(CHAR_COLON);
        push_number($urandom_range(0, 65535));
      end
      1: addr_text.push_back(CHAR_NUL);
      2: begin
        addr_text.push_back(CHAR_DOT);
        push_number($urandom_range(0, 255));
      end
      3: addr_text[$urandom_range(0, addr_text.size() - 1)] = 8'($urandom);
      4: begin
        cut = $urandom_range(0, addr_text.size() - 1);
        repeat (cut) void'(addr_text.pop_back());
      end
      default: ;
    endcase
    foreach (addr_text[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(random_item());
      it           = random_item();
      it.req_type  = REQ_CHAR;
      it.addr_char = addr_text[i];
      it.addr_last = (i == addr_text.size() - 1);
      send_item(it);
    end
  endtask

  // Stops offering requests and waits until every outstanding result has been taken, then
  // idles for QUIET_CYCLES for any request that gives no result.
  task automatic drain_outcomes();
    in_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_ban_mode(input logic mode);
    drain_outcomes();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ban_mode_m = mode;
  endtask

  function automatic out_item_t verdict(input logic rej, input logic hit,
                                        input logic [MIDX_W-1:0] idx, input logic [31:0] addr);
    return {KIND_VERDICT, 1'b0, rej, hit, idx, addr};
  endfunction

  function automatic void add_row(input logic [1:0] req, input logic [31:0] mask,
                                  input logic [31:0] cmp, input logic [7:0] chr,
                                  input logic last, input logic typed, input out_item_t res);
    plan_row_t row;
    row.req     = {req, mask, cmp, chr, last};
    row.typed   = typed;
    row.outcome = res;
    directed_plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result side: takes transfers and stalls in runs, with one long hold-off on request.
  // ---------------------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_outcome(out_data_o);
      if (hold_cycles_req != 0) begin
        stall_left      = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap(snk_idle_on);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------------------

  initial begin : stimulus
    in_item_t    it;
    int unsigned phase;
    int unsigned count;
    int unsigned random_goal;
    clear_parse();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with ban mode at its reset value of 1. Results that are obvious are
    // written out; the rest come from the model.
    add_row(REQ_CHAR,   '0, '0, "1", 1'b1, 1'b1, verdict(1'b0, 1'b0, '0, 32'h1));  // empty table
    add_row(REQ_APPEND, '0, '0, CHAR_NUL, 1'b0, 1'b1, ACK_KEPT);                   // match-all
    add_row(REQ_CHAR,   '0, '0, CHAR_COLON, 1'b1, 1'b1, verdict(1'b1, 1'b1, '0, '0));
    add_row(REQ_CLEAR,  '1, '1, 8'hFF, 1'b1, 1'b0, '0);                            // no result
    add_row(REQ_CHAR,   '0, '0, "7", 1'b1, 1'b1, verdict(1'b0, 1'b0, '0, 32'h7));
    add_row(REQ_APPEND, '1, '1, CHAR_NUL, 1'b0, 1'b1, ACK_KEPT);
    add_row(REQ_APPEND, 32'h0000_00FF, 32'h0000_002A, CHAR_NUL, 1'b0, 1'b1, ACK_KEPT);
    // "42", a non-digit separator, then 999 which wraps, ended by NUL.
    add_row(REQ_CHAR,   '0, '0, "4", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "2", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, 8'hFF, 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "9", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "9", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "9", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, CHAR_NUL, 1'b1, 1'b0, '0);
    add_row(REQ_UNUSED, '1, '1, 8'hFF, 1'b1, 1'b0, '0);                            // ignored
    // Four separators reach a fifth octet, so the digit marked last is ignored.
    add_row(REQ_CHAR,   '0, '0, CHAR_DOT, 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "a", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "/", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, CHAR_DOT, 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "5", 1'b1, 1'b0, '0);
    // 256 wraps to zero.
    add_row(REQ_CHAR,   '0, '0, "2", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "5", 1'b0, 1'b0, '0);
    add_row(REQ_CHAR,   '0, '0, "6", 1'b1, 1'b0, '0);
    foreach (directed_plan[i])
      send_item(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].outcome);

    // Random phases over small tables. Each phase starts from an idle block with a fresh ban
    // mode, so the sender pauses until every result is back at every phase boundary.
    phase       = 0;
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      set_ban_mode(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      it = random_item();
      it.req_type = REQ_CLEAR;
      send_item(it);
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
      repeat (count) send_item(append_item());
      if (phase == 3) begin
        // The receiver holds off for a long stretch while appends keep coming back to back,
        // so the acknowledgements back up and the block has to stall its input.
        hold_cycles_req = HOLD_CYCLES;
        src_idle_on     = 1'b0;
        repeat (40) send_item(append_item());
      end
      repeat ($urandom_range(3, 10)) begin
        if ($urandom_range(0, 9) == 0) send_item(random_item());
        send_address(target_address());
      end
      phase++;
    end

    // Full table: every slot written, a few appends dropped, then scans that run to the last
    // entry or through the whole table, in both ban modes.
    set_ban_mode(1'b1);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    it = random_item();
    it.req_type = REQ_CLEAR;
    send_item(it);
    repeat (TABLE_DEPTH + 3) begin
      it = append_item();
      it.entry_mask = '1;
      send_item(it);
    end
    repeat (3) send_address(tbl_compare[TABLE_DEPTH-1]);
    send_address(tbl_compare[$urandom_range(0, TABLE_DEPTH - 1)]);
    send_address($urandom);
    set_ban_mode(1'b0);
    repeat (2) send_address(tbl_compare[TABLE_DEPTH-1]);
    send_address($urandom);

    drain_outcomes();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
rtl/ipmf_pkg.sv
rtl/ipmf_table.sv
rtl/ipmf_parse.sv
rtl/ip_mask_filter_matcher.sv
dv/ip_mask_filter_matcher_tb.sv
